// ----- hdl/svc_pkg.sv -----
`default_nettype none

package svc_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned COUNT_W = 3;

   localparam logic OP_DECODE = 1'b0;
   localparam logic OP_ENCODE = 1'b1;

   localparam logic KIND_VALUE = 1'b0;
   localparam logic KIND_BYTE  = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_MAX  = 3'd7;
   localparam logic [COUNT_W-1:0] LONG_COUNT = 3'd4;
   localparam logic [COUNT_W-1:0] LAST_GROUP = 3'd4;

   typedef struct packed {
      logic              enc;
      logic [WORD_W-1:0] word;
   } entry_type;

endpackage

`default_nettype wire

// ----- hdl/svc_front.sv -----
`default_nettype none

module svc_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_op,
   input  wire logic [7:0]                 req_data_byte,
   input  wire logic signed [31:0]         req_value_in,
   output logic                            push_valid,
   output svc_pkg::entry_type              push_entry,
   input  wire logic                       push_stall
);

   logic [svc_pkg::WORD_W-1:0]  acc_ff, acc_in;
   logic [svc_pkg::COUNT_W-1:0] gc_ff, gc_in;
   logic                        accept;
   logic                        is_cont;
   logic [svc_pkg::WORD_W-1:0]  merged;
   logic [svc_pkg::WORD_W-1:0]  merged_rot;
   logic [svc_pkg::WORD_W-1:0]  short_mix;
   logic [svc_pkg::WORD_W-1:0]  dec_value;

   assign req_stall = push_stall;
   assign accept    = req_valid && !req_stall;
   assign is_cont   = req_data_byte[7];

   assign merged     = acc_ff | {25'd0, req_data_byte[6:0]};
   assign merged_rot = {merged[6:0], merged[31:7]};
   assign short_mix  = acc_ff | {28'd0, req_data_byte[3:0]};

   always_comb begin
      dec_value = '0;
      if (gc_ff >= svc_pkg::LONG_COUNT) begin
         dec_value = {short_mix[3:0], short_mix[31:4]};
      end else begin
         unique case (gc_ff[1:0])
            2'd0: dec_value = 32'($signed(merged_rot) >>> 25);
            2'd1: dec_value = 32'($signed(merged_rot) >>> 18);
            2'd2: dec_value = 32'($signed(merged_rot) >>> 11);
            2'd3: dec_value = 32'($signed(merged_rot) >>> 4);
            default: dec_value = '0;
         endcase
      end
   end

   always_comb begin
      push_valid = req_valid && (req_op == svc_pkg::OP_ENCODE || !is_cont);
      push_entry.enc  = (req_op == svc_pkg::OP_ENCODE);
      push_entry.word = (req_op == svc_pkg::OP_ENCODE) ? req_value_in : dec_value;
   end

   always_comb begin
      acc_in = acc_ff;
      gc_in  = gc_ff;
      if (accept && req_op == svc_pkg::OP_DECODE) begin
         if (is_cont) begin
            acc_in = merged_rot;
            gc_in  = (gc_ff == svc_pkg::COUNT_MAX) ? gc_ff : gc_ff + 3'd1;
         end else begin
            acc_in = '0;
            gc_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         gc_ff  <= '0;
      end else begin
         acc_ff <= acc_in;
         gc_ff  <= gc_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/svc_queue.sv -----
`default_nettype none

module svc_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   output logic                     push_stall,
   input  wire svc_pkg::entry_type  push_entry,
   output logic                     pop_valid,
   input  wire logic                pop_stall,
   output svc_pkg::entry_type       pop_entry
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   svc_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign push_stall = (count_ff == CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && !push_stall;
   assign do_pop     = pop_valid && !pop_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/svc_back.sv -----
`default_nettype none

module svc_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                pop_valid,
   output logic                     pop_stall,
   input  wire svc_pkg::entry_type  pop_entry,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_kind,
   output logic [7:0]               rsp_byte_out,
   output logic signed [31:0]       rsp_value_out,
   output logic                     rsp_last
);

   logic                        busy_ff, busy_in;
   logic [svc_pkg::WORD_W-1:0]  v_ff, v_in;
   logic [svc_pkg::COUNT_W-1:0] k_ff, k_in;
   logic                        valid_ff, valid_in;
   logic                        kind_ff, kind_in;
   logic [7:0]                  byte_ff, byte_in;
   logic [svc_pkg::WORD_W-1:0]  value_ff, value_in;
   logic                        last_ff, last_in;

   logic                        out_free;
   logic                        take;
   logic                        step;
   logic [svc_pkg::WORD_W-1:0]  src;
   logic [svc_pkg::COUNT_W-1:0] ksrc;
   logic                        fits;
   logic                        fin;

   assign out_free  = !valid_ff || !rsp_stall;
   assign pop_stall = busy_ff || !out_free;
   assign take      = pop_valid && !pop_stall;
   assign step      = busy_ff && out_free;

   assign src  = busy_ff ? v_ff : pop_entry.word;
   assign ksrc = busy_ff ? k_ff : '0;
   assign fits = (&src[31:6]) || !(|src[31:6]);
   assign fin  = fits || (ksrc >= svc_pkg::LAST_GROUP);

   always_comb begin
      busy_in  = busy_ff;
      v_in     = v_ff;
      k_in     = k_ff;
      valid_in = valid_ff;
      kind_in  = kind_ff;
      byte_in  = byte_ff;
      value_in = value_ff;
      last_in  = last_ff;
      if (out_free) begin
         valid_in = 1'b0;
      end
      if (step || (take && pop_entry.enc)) begin
         valid_in = 1'b1;
         kind_in  = svc_pkg::KIND_BYTE;
         byte_in  = {!fin, src[6:0]};
         value_in = '0;
         last_in  = fin;
         busy_in  = !fin;
         v_in     = {{7{src[31]}}, src[31:7]};
         k_in     = ksrc + 3'd1;
      end else if (take) begin
         valid_in = 1'b1;
         kind_in  = svc_pkg::KIND_VALUE;
         byte_in  = '0;
         value_in = pop_entry.word;
         last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
      v_ff     <= v_in;
      k_ff     <= k_in;
      kind_ff  <= kind_in;
      byte_ff  <= byte_in;
      value_ff <= value_in;
      last_ff  <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_byte_out  = byte_ff;
   assign rsp_value_out = value_ff;
   assign rsp_last      = last_ff;

endmodule

`default_nettype wire

// ----- hdl/signed_varint_codec_unit.sv -----
// An entry is registered in the queue, then in the back-end output stage that drives rsp_valid.
// Throughput: decode takes one byte per cycle while the queue has room; encode emits 1 to 5
// bytes per value, one per cycle unless rsp stalls, from the byte emitter in the back end.
// The queue between front and back end lets decoded values pile up while an encode drains.
// Reset (synchronous) clears the decode accumulator, group count, queue and emitter.
`default_nettype none

module signed_varint_codec_unit #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_op,
   input  wire logic [7:0]          req_data_byte,
   input  wire logic signed [31:0]  req_value_in,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_kind,
   output logic [7:0]               rsp_byte_out,
   output logic signed [31:0]       rsp_value_out,
   output logic                     rsp_last
);

   logic               push_valid;
   logic               push_stall;
   svc_pkg::entry_type push_entry;
   logic               pop_valid;
   logic               pop_stall;
   svc_pkg::entry_type pop_entry;

   svc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_data_byte (req_data_byte),
      .req_value_in  (req_value_in),
      .push_valid    (push_valid),
      .push_entry    (push_entry),
      .push_stall    (push_stall)
   );

   svc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_stall (push_stall),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_stall  (pop_stall),
      .pop_entry  (pop_entry)
   );

   svc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_stall     (pop_stall),
      .pop_entry     (pop_entry),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_byte_out  (rsp_byte_out),
      .rsp_value_out (rsp_value_out),
      .rsp_last      (rsp_last)
   );

`ifndef ASSERT_OFF
   a_value_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == svc_pkg::KIND_VALUE |-> rsp_last && rsp_byte_out == 8'd0)
      else $error("decoded value transaction not marked last");

   a_byte_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == svc_pkg::KIND_BYTE |-> rsp_last == !rsp_byte_out[7])
      else $error("continuation flag disagrees with last");

   a_byte_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == svc_pkg::KIND_BYTE |-> rsp_value_out == 32'sd0)
      else $error("encoded byte transaction carries a value");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_signed_varint_codec_unit.sv -----
`timescale 1ns / 100ps

module tb_signed_varint_codec_unit;

   localparam int unsigned TIMEOUT_NS = 600000;
   localparam int unsigned PRESSURE_HOLD = 60;

   typedef struct packed {
      logic        kind;
      logic [7:0]  octet;
      logic [31:0] value;
      logic        last;
   } codec_rsp_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_op;
   logic [7:0]         req_data_byte;
   logic signed [31:0] req_value_in;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_kind;
   logic [7:0]         rsp_byte_out;
   logic signed [31:0] rsp_value_out;
   logic               rsp_last;

   logic [31:0]    merge_word;
   logic [2:0]     merge_groups;
   codec_rsp_type  rsp_due[$];
   codec_rsp_type  rsp_got;
   codec_rsp_type  rsp_want;

   bit           req_idling;
   bit           rsp_idling;
   int           hold_request;
   int unsigned  fault_count;
   int unsigned  decodes_sent;
   int unsigned  encodes_sent;
   int unsigned  values_checked;
   int unsigned  bytes_checked;

   signed_varint_codec_unit uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_data_byte (req_data_byte),
      .req_value_in  (req_value_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_byte_out  (rsp_byte_out),
      .rsp_value_out (rsp_value_out),
      .rsp_last      (rsp_last)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic int pick_gap();
      return ($urandom_range(0, 9) == 0) ? int'($urandom_range(8, 30))
                                         : int'($urandom_range(1, 3));
   endfunction

   function automatic logic [31:0] rot_r(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] varied_value();
      logic [31:0] v;
      v = $urandom >> $urandom_range(0, 31);
      return ($urandom_range(0, 1) == 1) ? ~v : v;
   endfunction

   task automatic predict_decode(input logic [7:0] octet);
      logic [31:0] word;
      int          sh;
      if (octet[7]) begin
         merge_word = rot_r(merge_word | {25'd0, octet[6:0]}, 7);
         if (merge_groups != svc_pkg::COUNT_MAX)
            merge_groups = merge_groups + 3'd1;
      end else begin
         if (merge_groups >= svc_pkg::LONG_COUNT) begin
            word = rot_r(merge_word | {28'd0, octet[3:0]}, 4);
         end else begin
            sh = 25 - 7 * int'(merge_groups);
            word = $signed(rot_r(merge_word | {24'd0, octet}, 7)) >>> sh;
         end
         rsp_due.push_back(codec_rsp_type'{svc_pkg::KIND_VALUE, 8'h00, word, 1'b1});
         merge_word = '0;
         merge_groups = '0;
      end
   endtask

   task automatic predict_encode(input logic [31:0] value);
      logic [31:0] rest;
      logic [31:0] top;
      bit          done;
      int          k;
      rest = value;
      done = 1'b0;
      for (k = 0; k < 5 && !done; k++) begin
         top = $signed(rest) >>> 6;
         if (top == 32'h0 || top == 32'hFFFF_FFFF || k == 4) begin
            rsp_due.push_back(codec_rsp_type'{svc_pkg::KIND_BYTE, {1'b0, rest[6:0]},
                                              32'h0, 1'b1});
            done = 1'b1;
         end else begin
            rsp_due.push_back(codec_rsp_type'{svc_pkg::KIND_BYTE, {1'b1, rest[6:0]},
                                              32'h0, 1'b0});
            rest = $signed(rest) >>> 7;
         end
      end
   endtask

   task automatic send_item(input logic op, input logic [7:0] octet, input logic [31:0] word);
      int gap;
      gap = (req_idling && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_op        <= op;
      req_data_byte <= octet;
      req_value_in  <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == svc_pkg::OP_DECODE) begin
         decodes_sent++;
         predict_decode(octet);
      end else begin
         encodes_sent++;
         predict_encode(word);
      end
   endtask

   task automatic send_decode(input logic [7:0] octet);
      send_item(svc_pkg::OP_DECODE, octet, $urandom);
   endtask

   task automatic send_encode(input logic [31:0] value);
      send_item(svc_pkg::OP_ENCODE, 8'($urandom), value);
   endtask

   task automatic send_decode_run(input int groups);
      repeat (groups) send_decode(8'h80 | 8'($urandom_range(0, 127)));
   endtask

   task automatic test_short_values();
      send_decode(8'h3F);
      send_decode(8'h40);
      send_decode(8'h80);
      send_decode(8'h01);
   endtask

   task automatic test_five_byte_decode();
      send_decode(8'hFF);
      send_decode(8'hFF);
      send_decode(8'hFF);
      send_decode(8'hFF);
      send_decode(8'h07);
      send_decode(8'h80);
      send_decode(8'h80);
      send_decode(8'h80);
      send_decode(8'h80);
      send_decode(8'h78);
   endtask

   task automatic test_overlong_decode();
      repeat (6) send_decode(8'hAA);
      send_decode(8'h7F);
   endtask

   task automatic test_encode_between_decodes();
      send_decode(8'h85);
      send_encode(-32'sd300);
      send_decode(8'h02);
   endtask

   task automatic test_encode_extremes();
      send_encode(32'h0000_0000);
      send_encode(32'hFFFF_FFFF);
      send_encode(32'h0000_0040);
      send_encode(32'hFFFF_FFBF);
      send_encode(32'h7FFF_FFFF);
      send_encode(32'h8000_0000);
   endtask

   task automatic test_backpressure();
      hold_request = PRESSURE_HOLD;
      repeat (12) send_encode(32'h8000_0000 | $urandom);
      repeat (8) send_decode(8'($urandom_range(0, 127)));
   endtask

   task automatic test_random_traffic();
      int unsigned stop_at;
      stop_at = decodes_sent + encodes_sent + 150;
      req_idling = 1'b1;
      rsp_idling = 1'b1;
      while (decodes_sent + encodes_sent < stop_at) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               send_decode_run($urandom_range(0, 4));
               send_decode(8'($urandom_range(0, 127)));
            end
            6, 7: send_encode(varied_value());
            8: begin
               send_decode_run($urandom_range(5, 9));
               send_decode(8'($urandom_range(0, 127)));
            end
            default: begin
               send_decode_run($urandom_range(1, 3));
               send_encode(varied_value());
               send_decode(8'($urandom_range(0, 127)));
            end
         endcase
      end
   endtask

   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            n = hold_request;
            hold_request = 0;
            rsp_stall <= 1'b1;
            repeat (n - 1) @(negedge clock);
         end else if (rsp_idling && $urandom_range(0, 3) == 0) begin
            n = pick_gap();
            rsp_stall <= 1'b1;
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_got = '{rsp_kind, rsp_byte_out, rsp_value_out, rsp_last};
         if (rsp_due.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("%0t: unexpected transaction kind=%0d byte=%h value=%h last=%0d",
                        $realtime, rsp_kind, rsp_byte_out, rsp_value_out, rsp_last);
         end else begin
            rsp_want = rsp_due.pop_front();
            if (rsp_want.kind == svc_pkg::KIND_VALUE)
               values_checked++;
            else
               bytes_checked++;
            if (rsp_got != rsp_want) begin
               fault_count++;
               if (fault_count <= 10)
                  $display({"%0t: mismatch expected kind=%0d byte=%h value=%h last=%0d,",
                            " got kind=%0d byte=%h value=%h last=%0d"},
                           $realtime, rsp_want.kind, rsp_want.octet, rsp_want.value,
                           rsp_want.last, rsp_got.kind, rsp_got.octet, rsp_got.value,
                           rsp_got.last);
            end
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("signed_varint_codec_unit test failed");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_op        = svc_pkg::OP_DECODE;
      req_data_byte = 8'h00;
      req_value_in  = 32'sd0;
      merge_word    = '0;
      merge_groups  = '0;
      req_idling    = 1'b0;
      rsp_idling    = 1'b0;
      hold_request  = 0;
      fault_count   = 0;
      decodes_sent  = 0;
      encodes_sent  = 0;
      values_checked = 0;
      bytes_checked  = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      test_short_values();
      test_five_byte_decode();
      test_overlong_decode();
      test_encode_between_decodes();
      test_encode_extremes();
      test_backpressure();
      test_random_traffic();

      @(negedge clock);
      req_valid <= 1'b0;
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d decode bytes and %0d encode values, incl. overlong and held-off runs.",
               decodes_sent, encodes_sent);
      $display("Checked %0d decoded values and %0d encoded bytes, %0d faults.",
               values_checked, bytes_checked, fault_count);
      if (fault_count == 0 && rsp_due.size() == 0) begin
         $display("signed_varint_codec_unit test passed");
      end else begin
         $display("signed_varint_codec_unit test failed");
      end
      $finish;
   end

endmodule
